// ===== hdl/bts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bts_pkg;
    // defaults for the top level parameters
    localparam int DEF_MAX_DIM     = 256;
    localparam int DEF_WEIGHT_BITS = 8;

    // coordinate and store formats
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 17;
    localparam int STORE_AW   = 16;
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int TEXEL_W    = 32;
    localparam int SIZE_REG_W = 9;

    // register indexes on the configuration port
    localparam logic [1:0] REG_TEX_WIDTH   = 2'd0;
    localparam logic [1:0] REG_TEX_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_FILTER_MODE = 2'd2;

    // request kinds
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // filter modes
    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;
endpackage
`default_nettype wire

// ===== hdl/bts_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/bilinear_texture_sampler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  action, texel_index, texel_value, u_coord, v_coord
// m_        out        m_valid / m_ready  red, green, blue, alpha
// apb       in         psel / penable     tex_width, tex_height, filter_mode
//
// seven register stages: capture, scale multiply, split and clamp, address multiply,
// texel store read, horizontal blend, vertical blend; one request per cycle while m_ready does not stall
// the store is held as four copies, one per neighbour, so all four reads share a cycle
// a write request updates every copy at the store stage and returns nothing
// aresetn clears the valid bits and the configuration registers; the store has no reset
// a stall at m_ready freezes every stage together, nothing is dropped or repeated
module bilinear_texture_sampler #(
    parameter int MAX_DIM     = bts_pkg::DEF_MAX_DIM,
    parameter int WEIGHT_BITS = bts_pkg::DEF_WEIGHT_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [15:0] s_texel_index,
    input  wire logic [31:0] s_texel_value,
    input  wire logic [16:0] s_u_coord,
    input  wire logic [16:0] s_v_coord,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_red,
    output logic [7:0]       m_green,
    output logic [7:0]       m_blue,
    output logic [7:0]       m_alpha
);
    localparam int SZ_W   = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int PROD_W = SZ_W + bts_pkg::COORD_W + 1;
    localparam int POS_W  = SZ_W + 3;
    localparam int WB     = WEIGHT_BITS;
    localparam int AW     = bts_pkg::STORE_AW;
    localparam int FB     = bts_pkg::FRAC_BITS;
    localparam logic [WB:0] ONE = (WB+1)'(1) << WB;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FB - 1);

    // configuration registers
    logic [8:0] tex_width_reg, tex_height_reg;
    logic       filter_mode_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_width_reg   <= 9'd256;
            tex_height_reg  <= 9'd256;
            filter_mode_reg <= bts_pkg::MODE_BILINEAR;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                bts_pkg::REG_TEX_WIDTH:   tex_width_reg   <= pwdata[8:0];
                bts_pkg::REG_TEX_HEIGHT:  tex_height_reg  <= pwdata[8:0];
                bts_pkg::REG_FILTER_MODE: filter_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[3:2])
            bts_pkg::REG_TEX_WIDTH:   prdata = {23'd0, tex_width_reg};
            bts_pkg::REG_TEX_HEIGHT:  prdata = {23'd0, tex_height_reg};
            bts_pkg::REG_FILTER_MODE: prdata = {31'd0, filter_mode_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // effective size: zero acts as one, large values saturate
    function automatic logic [SZ_W-1:0] eff_size(input logic [8:0] r);
        logic [SZ_W+9:0] rw;
        rw = (SZ_W+10)'(r);
        if (r == 9'd0) return SZ_W'(1);
        if (rw > (SZ_W+10)'(MAX_DIM)) return SZ_W'(MAX_DIM);
        return rw[SZ_W-1:0];
    endfunction

    // clamp a signed position to 0..size-1
    function automatic logic [IDX_W-1:0] clamp_pos(input logic signed [POS_W-1:0] p,
                                                  input logic [SZ_W-1:0] size);
        logic signed [POS_W-1:0] lim;
        lim = $signed({3'b000, size}) - POS_W'(1);
        if (p < 0) return '0;
        if (p > lim) return lim[IDX_W-1:0];
        return p[IDX_W-1:0];
    endfunction

    // global advance: every stage moves unless the result waits
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage 0: capture
    logic                v0_reg, act0_reg, bil0_reg;
    logic [15:0]         idx0_reg;
    logic [31:0]         val0_reg;
    logic [16:0]         u0_reg, vc0_reg;
    logic [SZ_W-1:0]     w0_reg, h0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act0_reg <= s_action;
            idx0_reg <= s_texel_index;
            val0_reg <= s_texel_value;
            u0_reg   <= s_u_coord;
            vc0_reg  <= s_v_coord;
            w0_reg   <= eff_size(tex_width_reg);
            h0_reg   <= eff_size(tex_height_reg);
            bil0_reg <= filter_mode_reg;
        end
    end

    // stage 1: scale coordinates by the texture size
    logic                v1_reg, act1_reg, bil1_reg;
    logic [15:0]         idx1_reg;
    logic [31:0]         val1_reg;
    logic [SZ_W-1:0]     w1_reg, h1_reg;
    logic [PROD_W-1:0]   px1_reg, py1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act1_reg <= act0_reg;
            bil1_reg <= bil0_reg;
            idx1_reg <= idx0_reg;
            val1_reg <= val0_reg;
            w1_reg   <= w0_reg;
            h1_reg   <= h0_reg;
            px1_reg  <= PROD_W'(w0_reg) * PROD_W'(u0_reg);
            py1_reg  <= PROD_W'(h0_reg) * PROD_W'(vc0_reg);
        end
    end

    // stage 2: half-texel offset (bilinear mode only), split and edge clamp
    logic [PROD_W-1:0]       pxf, pyf;
    logic signed [POS_W-1:0] posx, posy;
    logic [WB-1:0]           fx_c, fy_c;

    always_comb begin
        pxf  = bil1_reg ? px1_reg + HALF : px1_reg;
        pyf  = bil1_reg ? py1_reg + HALF : py1_reg;
        posx = $signed(POS_W'(pxf >> FB)) - (bil1_reg ? POS_W'(1) : POS_W'(0));
        posy = $signed(POS_W'(pyf >> FB)) - (bil1_reg ? POS_W'(1) : POS_W'(0));
        fx_c = bil1_reg ? pxf[FB-1 -: WB] : '0;
        fy_c = bil1_reg ? pyf[FB-1 -: WB] : '0;
    end

    logic                v2_reg, act2_reg;
    logic [15:0]         idx2_reg;
    logic [31:0]         val2_reg;
    logic [SZ_W-1:0]     w2_reg;
    logic [IDX_W-1:0]    x0_reg, x1_reg, y0_reg, y1_reg;
    logic [WB-1:0]       fx2_reg, fy2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act2_reg <= act1_reg;
            idx2_reg <= idx1_reg;
            val2_reg <= val1_reg;
            w2_reg   <= w1_reg;
            x0_reg   <= clamp_pos(posx, w1_reg);
            x1_reg   <= clamp_pos(posx + POS_W'(1), w1_reg);
            y0_reg   <= clamp_pos(posy, h1_reg);
            y1_reg   <= clamp_pos(posy + POS_W'(1), h1_reg);
            fx2_reg  <= fx_c;
            fy2_reg  <= fy_c;
        end
    end

    // stage 3: row-major store addresses, or the write address
    localparam int ROW_W = IDX_W + SZ_W + 1;
    logic [ROW_W-1:0] row0, row1;
    logic [AW-1:0]    addr_c [4];

    always_comb begin
        row0 = ROW_W'(y0_reg) * ROW_W'(w2_reg);
        row1 = ROW_W'(y1_reg) * ROW_W'(w2_reg);
        if (act2_reg == bts_pkg::ACT_WRITE) begin
            for (int k = 0; k < 4; k++) addr_c[k] = idx2_reg;
        end else begin
            addr_c[0] = AW'(row0 + ROW_W'(x0_reg));
            addr_c[1] = AW'(row0 + ROW_W'(x1_reg));
            addr_c[2] = AW'(row1 + ROW_W'(x0_reg));
            addr_c[3] = AW'(row1 + ROW_W'(x1_reg));
        end
    end

    logic                v3_reg, act3_reg;
    logic [31:0]         val3_reg;
    logic [AW-1:0]       addr3_reg [4];
    logic [WB-1:0]       fx3_reg, fy3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act3_reg  <= act2_reg;
            val3_reg  <= val2_reg;
            addr3_reg <= addr_c;
            fx3_reg   <= fx2_reg;
            fy3_reg   <= fy2_reg;
        end
    end

    // stage 4: texel store, one copy per neighbour
    logic        st_we;
    logic [31:0] texel [4];

    assign st_we = v3_reg && (act3_reg == bts_pkg::ACT_WRITE);

    for (genvar k = 0; k < 4; k++) begin : g_store
        bts_ram #(
            .WIDTH(bts_pkg::TEXEL_W),
            .DEPTH(bts_pkg::STORE_DEPTH)
        ) u_ram (
            .aclk (aclk),
            .en   (en),
            .we   (st_we),
            .addr (addr3_reg[k]),
            .wdata(val3_reg),
            .rdata(texel[k])
        );
    end

    logic          v4_reg, smp4_reg;
    logic [WB-1:0] fx4_reg, fy4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            smp4_reg <= (act3_reg == bts_pkg::ACT_SAMPLE);
            fx4_reg  <= fx3_reg;
            fy4_reg  <= fy3_reg;
        end
    end

    // stage 5: horizontal blend per channel
    localparam int TOP_W = 8 + WB + 1;
    localparam int SUM_W = TOP_W + WB + 1;
    logic [WB:0]      wx0, wx1;
    logic [TOP_W-1:0] top_reg [4];
    logic [TOP_W-1:0] bot_reg [4];
    logic             v5_reg, smp5_reg;
    logic [WB-1:0]    fy5_reg;

    assign wx1 = (WB+1)'(fx4_reg);
    assign wx0 = ONE - wx1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_hblend
        always_ff @(posedge aclk) begin
            if (en) begin
                top_reg[c] <= TOP_W'(texel[0][8*c +: 8]) * TOP_W'(wx0)
                            + TOP_W'(texel[1][8*c +: 8]) * TOP_W'(wx1);
                bot_reg[c] <= TOP_W'(texel[2][8*c +: 8]) * TOP_W'(wx0)
                            + TOP_W'(texel[3][8*c +: 8]) * TOP_W'(wx1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            smp5_reg <= smp4_reg;
            fy5_reg  <= fy4_reg;
        end
    end

    // stage 6: vertical blend and truncation into the result register
    logic [WB:0]      wy0, wy1;
    logic [SUM_W-1:0] sum_c [4];
    logic             m_valid_reg;
    logic [7:0]       chan_reg [4];

    assign wy1 = (WB+1)'(fy5_reg);
    assign wy0 = ONE - wy1;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            sum_c[c] = SUM_W'(top_reg[c]) * SUM_W'(wy0) + SUM_W'(bot_reg[c]) * SUM_W'(wy1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v5_reg && smp5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) chan_reg[c] <= sum_c[c][2*WB +: 8];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_red   = chan_reg[0];
    assign m_green = chan_reg[1];
    assign m_blue  = chan_reg[2];
    assign m_alpha = chan_reg[3];
endmodule
`default_nettype wire
